// ===== rtl/sobel_edge_filter_rgb_macros.svh =====
// Assertion macros for the horizontal Sobel edge filter
`ifndef SOBEL_EDGE_FILTER_RGB_MACROS_SVH
`define SOBEL_EDGE_FILTER_RGB_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SEF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SEF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/sef_pkg.sv =====
// Shared constants, types and helpers for the horizontal Sobel edge filter
`default_nettype none

package sef_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int HEIGHT_LIMIT = 1024;
  localparam int MIN_DIM      = 3;

  localparam int PIX_W  = 8;
  localparam int SUM_W  = 10;
  localparam int CFG_W  = 11;
  localparam int IDX_W  = 2;
  localparam int EDGE_W = 8;
  localparam int POS_W  = 10;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(HEIGHT_LIMIT);
  localparam int G_W    = SUM_W + 3;
  localparam int V_W    = 10;

  localparam int EDGE_OFFSET = 127;
  localparam int EDGE_MAX    = 255;
  localparam int DIV_SHIFT   = 3;

  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = IDX_W'(1);

  typedef logic [SUM_W-1:0] sum_t;
  typedef logic [COL_W-1:0] col_t;
  typedef logic [ROW_W-1:0] row_t;

  // last column index for a programmed width, clamped to the legal range
  function automatic col_t width_last(input logic [CFG_W-1:0] v);
    int lim;
    lim = int'(v);
    if (lim < MIN_DIM) lim = MIN_DIM;
    if (lim > MAX_WIDTH) lim = MAX_WIDTH;
    return COL_W'(lim - 1);
  endfunction

  // last row index for a programmed height, clamped to the legal range
  function automatic row_t height_last(input logic [CFG_W-1:0] v);
    int lim;
    lim = int'(v);
    if (lim < MIN_DIM) lim = MIN_DIM;
    if (lim > HEIGHT_LIMIT) lim = HEIGHT_LIMIT;
    return ROW_W'(lim - 1);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sef_pix_if.sv =====
// Pixel input channel: valid/ready plus one RGB pixel per beat
`default_nettype none

interface sef_pix_if;
  logic                        valid;
  logic                        ready;
  logic [sef_pkg::PIX_W-1:0]   red_sample;
  logic [sef_pkg::PIX_W-1:0]   green_sample;
  logic [sef_pkg::PIX_W-1:0]   blue_sample;

  modport source (output valid, red_sample, green_sample, blue_sample, input ready);
  modport sink   (input valid, red_sample, green_sample, blue_sample, output ready);
endinterface

`default_nettype wire

// ===== rtl/sef_res_if.sv =====
// Result channel: valid/ready plus one edge value with its center position
`default_nettype none

interface sef_res_if;
  logic                        valid;
  logic                        ready;
  logic [sef_pkg::EDGE_W-1:0]  edge_value;
  logic [sef_pkg::POS_W-1:0]   center_col;
  logic [sef_pkg::POS_W-1:0]   center_row;
  logic                        frame_done;

  modport source (output valid, edge_value, center_col, center_row, frame_done, input ready);
  modport sink   (input valid, edge_value, center_col, center_row, frame_done, output ready);
endinterface

`default_nettype wire

// ===== rtl/sef_cfg_if.sv =====
// Configuration write channel: valid/ready, register index and write data
`default_nettype none

interface sef_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [sef_pkg::IDX_W-1:0]   reg_index;
  logic [sef_pkg::CFG_W-1:0]   wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

// ===== rtl/sef_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module sef_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sobel_edge_filter_rgb.sv =====
// Horizontal Sobel edge filter over a raster-order RGB pixel stream
//
// in_pix takes one RGB pixel per beat in raster order; out_res gives one
// edge value per interior center pixel with its column, row and a flag on
// the frame's last result. Border pixels give no beat. cfg_wr programs
// image width (index 0) and height (index 1); write only while idle.
// Throughput: one pixel per clock while out_res is not stalled. The
// per-pixel work is a read of two 1024-entry line buffers at the current
// column, done as the pixel is taken into the input stage, then a fixed
// add tree into the result register as the pixel leaves that stage.
// Reset clears the column/row counters, the window and both pipeline
// valids and loads width 640, height 480. Line buffer contents are not
// cleared; they are written by the first two rows of each frame before use.
// When the receiver stalls, the result register holds and border pixels
// still pass; the next pixel that gives a result waits in the input stage
// with in_pix.ready low until the result register frees.
`default_nettype none

module sobel_edge_filter_rgb (
  input  wire logic   clk,
  input  wire logic   rst_n,
  sef_pix_if.sink     in_pix,
  sef_res_if.source   out_res,
  sef_cfg_if.sink     cfg_wr
);

  sef_pkg::col_t width_last_r;
  sef_pkg::row_t height_last_r;

  sef_pkg::col_t col_r;
  sef_pkg::row_t row_r;

  logic          a_vld_r;
  sef_pkg::sum_t a_sum_r;
  sef_pkg::col_t a_col_r;
  sef_pkg::row_t a_row_r;
  logic          a_emit_r;
  logic          a_done_r;

  sef_pkg::sum_t win_c1_r [3];
  sef_pkg::sum_t win_c2_r [3];

  logic                        out_vld_r;
  logic [sef_pkg::EDGE_W-1:0]  edge_value_r;
  logic [sef_pkg::POS_W-1:0]   center_col_r;
  logic [sef_pkg::POS_W-1:0]   center_row_r;
  logic                        frame_done_r;

  logic          in_acc;
  logic          b_go;
  logic          last_col;
  logic          last_row;
  sef_pkg::sum_t pix_sum;
  sef_pkg::sum_t up_q;
  sef_pkg::sum_t mid_q;

  logic signed [sef_pkg::G_W-1:0] g;
  logic signed [sef_pkg::G_W-1:0] g_div;
  logic signed [sef_pkg::V_W-1:0] v;
  logic [sef_pkg::EDGE_W-1:0]     edge_nxt;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_last_r  <= sef_pkg::width_last(sef_pkg::CFG_W'(sef_pkg::WIDTH_RESET));
      height_last_r <= sef_pkg::height_last(sef_pkg::CFG_W'(sef_pkg::HEIGHT_RESET));
    end else if (cfg_wr.valid) begin
      case (cfg_wr.reg_index)
        sef_pkg::REG_IMAGE_WIDTH:  width_last_r  <= sef_pkg::width_last(cfg_wr.wdata);
        sef_pkg::REG_IMAGE_HEIGHT: height_last_r <= sef_pkg::height_last(cfg_wr.wdata);
        default: ;
      endcase
    end
  end

  // input stage
  assign b_go         = a_vld_r && (!a_emit_r || !out_vld_r || out_res.ready);
  assign in_pix.ready = !a_vld_r || b_go;
  assign in_acc       = in_pix.valid && in_pix.ready;

  assign last_col = (col_r >= width_last_r);
  assign last_row = (row_r >= height_last_r);
  assign pix_sum  = sef_pkg::SUM_W'(in_pix.red_sample) + sef_pkg::SUM_W'(in_pix.green_sample)
                  + sef_pkg::SUM_W'(in_pix.blue_sample);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      a_vld_r <= 1'b0;
    end else begin
      if (in_acc) begin
        a_vld_r <= 1'b1;
        if (last_col) begin
          col_r <= '0;
          row_r <= last_row ? '0 : row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end else if (b_go) begin
        a_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_sum_r  <= pix_sum;
      a_col_r  <= col_r;
      a_row_r  <= row_r;
      a_emit_r <= (col_r >= sef_pkg::COL_W'(2)) && (row_r >= sef_pkg::ROW_W'(2));
      a_done_r <= last_col && last_row;
    end
  end

  // line buffers: read at the incoming column, rotate on the way out
  sef_ram #(.WIDTH(sef_pkg::SUM_W), .DEPTH(sef_pkg::MAX_WIDTH)) u_lb_upper (
    .clk   (clk),
    .we    (b_go),
    .waddr (a_col_r),
    .wdata (mid_q),
    .re    (in_acc),
    .raddr (col_r),
    .rdata (up_q)
  );

  sef_ram #(.WIDTH(sef_pkg::SUM_W), .DEPTH(sef_pkg::MAX_WIDTH)) u_lb_middle (
    .clk   (clk),
    .we    (b_go),
    .waddr (a_col_r),
    .wdata (a_sum_r),
    .re    (in_acc),
    .raddr (col_r),
    .rdata (mid_q)
  );

  // gradient: left column minus incoming right column, weights 1,2,1
  always_comb begin
    g = (sef_pkg::G_W'($signed({1'b0, win_c1_r[0]})) - sef_pkg::G_W'($signed({1'b0, up_q})))
      + ((sef_pkg::G_W'($signed({1'b0, win_c1_r[1]}))
         - sef_pkg::G_W'($signed({1'b0, mid_q}))) <<< 1)
      + (sef_pkg::G_W'($signed({1'b0, win_c1_r[2]})) - sef_pkg::G_W'($signed({1'b0, a_sum_r})));
    if (g < 0) begin
      g_div = (g + sef_pkg::G_W'(7)) >>> sef_pkg::DIV_SHIFT;
    end else begin
      g_div = g >>> sef_pkg::DIV_SHIFT;
    end
    v = sef_pkg::V_W'(g_div) + sef_pkg::V_W'(sef_pkg::EDGE_OFFSET);
    if (v < 0) begin
      edge_nxt = '0;
    end else if (v > sef_pkg::V_W'(sef_pkg::EDGE_MAX)) begin
      edge_nxt = sef_pkg::EDGE_W'(sef_pkg::EDGE_MAX);
    end else begin
      edge_nxt = sef_pkg::EDGE_W'(v);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        win_c1_r[i] <= '0;
        win_c2_r[i] <= '0;
      end
    end else if (b_go) begin
      for (int i = 0; i < 3; i++) begin
        win_c1_r[i] <= win_c2_r[i];
      end
      win_c2_r[0] <= up_q;
      win_c2_r[1] <= mid_q;
      win_c2_r[2] <= a_sum_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (b_go && a_emit_r) begin
      out_vld_r <= 1'b1;
    end else if (out_res.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go && a_emit_r) begin
      edge_value_r <= edge_nxt;
      center_col_r <= sef_pkg::POS_W'(a_col_r - 1'b1);
      center_row_r <= sef_pkg::POS_W'(a_row_r - 1'b1);
      frame_done_r <= a_done_r;
    end
  end

  assign out_res.valid      = out_vld_r;
  assign out_res.edge_value = edge_value_r;
  assign out_res.center_col = center_col_r;
  assign out_res.center_row = center_row_r;
  assign out_res.frame_done = frame_done_r;

endmodule

`default_nettype wire

// ===== rtl/sef_checker.sv =====
// Port-level checks for the horizontal Sobel edge filter, bound to the top level
`default_nettype none

`include "sobel_edge_filter_rgb_macros.svh"

module sef_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [sef_pkg::EDGE_W-1:0] edge_value,
  input wire logic [sef_pkg::POS_W-1:0]  center_col,
  input wire logic [sef_pkg::POS_W-1:0]  center_row,
  input wire logic                       frame_done
);

  `SEF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped while stalled")
  `SEF_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(edge_value) && $stable(center_col) && $stable(center_row) && $stable(frame_done), "result payload changed while stalled")
  `SEF_ASSERT_NOW(a_out_from_pix, $rose(out_valid), $past(in_valid && in_ready, 2), "result beat without a pixel two cycles earlier")
  `SEF_ASSERT_NOW(a_center_interior, out_valid, center_col != '0 && center_row != '0, "result center on the frame border")

endmodule

bind sobel_edge_filter_rgb sef_checker u_sef_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_pix.valid),
  .in_ready   (in_pix.ready),
  .out_valid  (out_res.valid),
  .out_ready  (out_res.ready),
  .edge_value (out_res.edge_value),
  .center_col (out_res.center_col),
  .center_row (out_res.center_row),
  .frame_done (out_res.frame_done)
);

`default_nettype wire
